>>> rtl/irpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irpq_pkg;

    // register and field widths
    localparam int CFG_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int PULSE_W    = 16;
    localparam int IDX_W      = 7;
    localparam int SYM_CNT_W  = 4;
    localparam int CODE_W     = 20;

    // head mark must start within this many pulses of the burst
    localparam logic [IDX_W-1:0] HEAD_SEARCH_PULSES = 7'd10;
    localparam logic [IDX_W-1:0] IDX_MAX            = 7'd127;
    localparam logic [SYM_CNT_W-1:0] FRAME_SYMBOLS  = 4'd10;

    // depth of the queue between classifier and decoder
    localparam int Q_DEPTH = 2;

    // register reset values
    localparam logic [CFG_W-1:0] RST_HEAD_MARK  = 14'd1009;
    localparam logic [CFG_W-1:0] RST_HEAD_SPACE = 14'd588;
    localparam logic [CFG_W-1:0] RST_SYM0       = 14'd588;
    localparam logic [CFG_W-1:0] RST_SYM1       = 14'd882;
    localparam logic [CFG_W-1:0] RST_SYM2       = 14'd1176;
    localparam logic [CFG_W-1:0] RST_SYM3       = 14'd1470;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_MARK  = 3'd0,
        CFG_HEAD_SPACE = 3'd1,
        CFG_SYM0       = 3'd2,
        CFG_SYM1       = 3'd3,
        CFG_SYM2       = 3'd4,
        CFG_SYM3       = 3'd5
    } t_cfg_idx;

    // symbol codes
    typedef enum logic [1:0] {
        SYM_00 = 2'd0,
        SYM_01 = 2'd1,
        SYM_10 = 2'd2,
        SYM_11 = 2'd3
    } t_sym;

    // one captured pulse
    typedef struct packed {
        logic [PULSE_W-1:0] pulse_us;
        logic               pulse_level;
        logic               last_pulse;
    } t_in_item;

    // one decoded burst
    typedef struct packed {
        logic       frame_found;
        logic [7:0] address;
        logic [7:0] command;
        logic [3:0] check_nibble;
        logic       check_ok;
        logic [3:0] symbol_count;
    } t_out_item;

    // classified pulse handed from front to back
    typedef struct packed {
        logic mark_ok;
        logic space_ok;
        logic sym_ok;
        t_sym sym;
        logic last;
    } t_pulse_class;

endpackage

`default_nettype wire

>>> rtl/irpq_front.sv
`timescale 1ns / 1ps
`default_nettype none

module irpq_front
    import irpq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire t_in_item             i_item,
    output t_pulse_class              o_class
);

    logic [CFG_W-1:0] r_head_mark, r_head_space;
    logic [CFG_W-1:0] r_sym0, r_sym1, r_sym2, r_sym3;

    // strict +-20% window: 5p > 4n and 5p < 6n
    function automatic logic head_win(input logic [PULSE_W-1:0] p, input logic [CFG_W-1:0] n);
        logic [18:0] p5;
        logic [18:0] n4;
        logic [18:0] n6;
        begin
            p5 = (19'(p) << 2) + 19'(p);
            n4 = 19'(n) << 2;
            n6 = (19'(n) << 2) + (19'(n) << 1);
            head_win = (p5 > n4) && (p5 < n6);
        end
    endfunction

    // inclusive floor(0.9n)..floor(1.1n): 10p + 10 > 9n and 10p <= 11n
    function automatic logic sym_win(input logic [PULSE_W-1:0] p, input logic [CFG_W-1:0] n);
        logic [19:0] p10;
        logic [19:0] n9;
        logic [19:0] n11;
        begin
            p10 = (20'(p) << 3) + (20'(p) << 1);
            n9  = (20'(n) << 3) + 20'(n);
            n11 = (20'(n) << 3) + (20'(n) << 1) + 20'(n);
            sym_win = ((p10 + 20'd10) > n9) && (p10 <= n11);
        end
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_mark  <= RST_HEAD_MARK;
            r_head_space <= RST_HEAD_SPACE;
            r_sym0       <= RST_SYM0;
            r_sym1       <= RST_SYM1;
            r_sym2       <= RST_SYM2;
            r_sym3       <= RST_SYM3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEAD_MARK:  r_head_mark  <= i_cfg_data;
                CFG_HEAD_SPACE: r_head_space <= i_cfg_data;
                CFG_SYM0:       r_sym0       <= i_cfg_data;
                CFG_SYM1:       r_sym1       <= i_cfg_data;
                CFG_SYM2:       r_sym2       <= i_cfg_data;
                CFG_SYM3:       r_sym3       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window classification of the incoming pulse
    logic w0, w1, w2, w3;
    assign w0 = sym_win(i_item.pulse_us, r_sym0);
    assign w1 = sym_win(i_item.pulse_us, r_sym1);
    assign w2 = sym_win(i_item.pulse_us, r_sym2);
    assign w3 = sym_win(i_item.pulse_us, r_sym3);

    always_comb begin
        o_class.mark_ok  = i_item.pulse_level && head_win(i_item.pulse_us, r_head_mark);
        o_class.space_ok = !i_item.pulse_level && head_win(i_item.pulse_us, r_head_space);
        o_class.sym_ok   = w0 || w1 || w2 || w3;
        o_class.last     = i_item.last_pulse;
        // first matching window wins
        priority if (w0) o_class.sym = SYM_00;
        else if (w1)     o_class.sym = SYM_01;
        else if (w2)     o_class.sym = SYM_10;
        else if (w3)     o_class.sym = SYM_11;
        else             o_class.sym = SYM_00;
    end

endmodule

`default_nettype wire

>>> rtl/irpq_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module irpq_queue
    import irpq_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_pulse_class i_data,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_pulse_class o_data
);

    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);
    localparam logic [QPW-1:0] PTR_LAST = QPW'(Q_DEPTH - 1);
    localparam logic [QCW-1:0] CNT_FULL = QCW'(Q_DEPTH);

    t_pulse_class     r_mem [Q_DEPTH];
    logic [QPW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]   r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/irpq_back.sv
`timescale 1ns / 1ps
`default_nettype none

module irpq_back
    import irpq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_pulse_class i_class,
    output logic         o_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_item    o_out_data
);

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_DECODE = 3'b010,
        PH_STOP   = 3'b100
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_hms, n_hms;
    logic                   r_exp, n_exp;
    logic [SYM_CNT_W-1:0]   r_cnt, n_cnt;
    logic [CODE_W-1:0]      r_code, n_code;
    logic                   r_out_valid;
    t_out_item              r_out, n_out;
    logic                   found;

    // take a pulse unless it ends a burst and the result slot is busy
    assign o_pop       = i_valid && (!i_class.last || !r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // burst state update for one pulse
    always_comb begin
        n_phase = r_phase;
        n_hms   = r_hms;
        n_exp   = r_exp;
        n_cnt   = r_cnt;
        n_code  = r_code;
        found   = 1'b0;
        unique case (r_phase)
            PH_SEARCH: begin
                found = r_hms && i_class.space_ok;
                if (found) begin
                    n_phase = PH_DECODE;
                    n_exp   = 1'b0;
                end
                n_hms = !found && (r_idx < HEAD_SEARCH_PULSES) && i_class.mark_ok;
            end
            PH_DECODE: begin
                n_exp = !r_exp;
                if (r_exp) begin
                    if (!i_class.sym_ok) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_code = {r_code[CODE_W-3:0], i_class.sym};
                        n_cnt  = r_cnt + 1'b1;
                        if (r_cnt + 1'b1 >= FRAME_SYMBOLS) begin
                            n_phase = PH_STOP;
                        end
                    end
                end
            end
            PH_STOP: ;
            default: n_phase = PH_SEARCH;
        endcase
        n_idx = (r_idx < IDX_MAX) ? r_idx + 1'b1 : r_idx;
    end

    // result fields from the state after this pulse
    always_comb begin
        logic [SYM_CNT_W-1:0] n;
        logic [3:0]           x;
        n_out = '0;
        n = (n_phase != PH_SEARCH) ? n_cnt : '0;
        n_out.frame_found  = (n_phase != PH_SEARCH);
        n_out.symbol_count = n;
        unique case (n)
            4'd1: n_out.address = {4'b0, n_code[1:0], 2'b0};
            4'd2: n_out.address = {2'b0, n_code[3:0], 2'b0};
            4'd3: n_out.address = {n_code[5:0], 2'b0};
            4'd4: n_out.address = n_code[7:0];
            4'd5: begin
                n_out.address = n_code[9:2];
                n_out.command = {4'b0, n_code[1:0], 2'b0};
            end
            4'd6: begin
                n_out.address = n_code[11:4];
                n_out.command = {2'b0, n_code[3:0], 2'b0};
            end
            4'd7: begin
                n_out.address = n_code[13:6];
                n_out.command = {n_code[5:0], 2'b0};
            end
            4'd8: begin
                n_out.address = n_code[15:8];
                n_out.command = n_code[7:0];
            end
            4'd9: begin
                n_out.address      = n_code[17:10];
                n_out.command      = n_code[9:2];
                n_out.check_nibble = {n_code[1:0], 2'b0};
            end
            4'd10: begin
                n_out.address      = n_code[19:12];
                n_out.command      = n_code[11:4];
                n_out.check_nibble = n_code[3:0];
            end
            default: ;
        endcase
        x = n_out.address[7:4] ^ n_out.address[3:0]
            ^ n_out.command[7:4] ^ n_out.command[3:0];
        n_out.check_ok = n_out.frame_found && (x == n_out.check_nibble);
    end

    // burst state registers, cleared after the last pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_idx   <= '0;
            r_hms   <= 1'b0;
            r_exp   <= 1'b0;
            r_cnt   <= '0;
            r_code  <= '0;
        end else if (o_pop) begin
            if (i_class.last) begin
                r_phase <= PH_SEARCH;
                r_idx   <= '0;
                r_hms   <= 1'b0;
                r_exp   <= 1'b0;
                r_cnt   <= '0;
                r_code  <= '0;
            end else begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_hms   <= n_hms;
                r_exp   <= n_exp;
                r_cnt   <= n_cnt;
                r_code  <= n_code;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_class.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_class.last) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ir_pulse_width_quad_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Infrared pulse-distance decoder with 2-bit symbols. One captured pulse
// (duration, level, last-of-burst flag) is taken per clock while the
// two-entry queue between the window classifier and the burst decoder
// is not full; it and a registered result stage keep pulses flowing
// while a result waits, but a burst's last pulse waits for the result
// slot, loaded when the decoder pops that pulse. Registers are written
// through the plain write port (index 0 head mark, 1 head space, 2..5
// symbol spaces 00..11, 14 bits each) and should only change while the
// decoder is idle. No clearing pass is needed after reset.
module ir_pulse_width_quad_decoder
    import irpq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data
);

    t_pulse_class front_class, q_class;
    logic         q_full, q_valid, q_pop, q_push;

    assign o_in_stall = q_full;
    assign q_push     = i_in_valid && !q_full;

    // window classification and registers
    irpq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .o_class    (front_class)
    );

    // decoupling queue
    irpq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_class),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_class)
    );

    // burst decoding and result stage
    irpq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_class     (q_class),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> rtl/irpq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module irpq_checker
    import irpq_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // a burst without head reports all zero
    a_no_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.frame_found |->
            o_out_data.address == 8'd0 && o_out_data.command == 8'd0 &&
            o_out_data.check_nibble == 4'd0 && !o_out_data.check_ok &&
            o_out_data.symbol_count == 4'd0)
        else $error("fields set without head");

    // symbol count never passes a full frame
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.symbol_count <= FRAME_SYMBOLS)
        else $error("symbol count out of range");

    // command and check stay empty until their symbols arrive
    a_partial_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.symbol_count < 4'd5 |->
            o_out_data.command == 8'd0 && o_out_data.check_nibble == 4'd0)
        else $error("command or check set too early");

endmodule

bind ir_pulse_width_quad_decoder irpq_checker u_irpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
